[design/qas_pkg.sv]
// ============================================================================
// qas_pkg
// Shared types and constants of the quoted argument splitter: the result
// record, status codes and the special characters of the line syntax.
// ============================================================================
`default_nettype none

package qas_pkg;

    localparam logic [7:0] CHAR_BACKSLASH    = 8'h5C;
    localparam logic [7:0] CHAR_SINGLE_QUOTE = 8'h27;
    localparam logic [7:0] CHAR_DOUBLE_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_NUL          = 8'h00;
    localparam logic [7:0] CHAR_SPACE        = 8'h20;
    localparam logic [7:0] CHAR_TAB          = 8'h09;
    localparam logic [7:0] CHAR_CR           = 8'h0D;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_OPEN_ESCAPE  = 2'd1;
    localparam logic [1:0] STATUS_OPEN_SINGLE  = 2'd2;
    localparam logic [1:0] STATUS_OPEN_DOUBLE  = 2'd3;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic       write_enable;
        logic [7:0] write_byte;
        logic [7:0] write_position;
        logic       mark_enable;
        logic [3:0] mark_slot;
        logic       done_res;
        logic [1:0] status;
        logic [4:0] argument_total;
    } qas_result_t;

endpackage

`default_nettype wire

[design/qas_core.sv]
// ============================================================================
// qas_core
// Tokenizer state machine: holds the mode, write pointer and argument count,
// and forms the result for the request presented at its input.
// ============================================================================
`default_nettype none

module qas_core #(
    parameter int LINE_MAX  = 256,
    parameter int ARG_SLOTS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire logic [7:0]          char_byte,
    input  wire logic                end_of_text,
    input  wire logic [4:0]          argument_limit,
    output qas_pkg::qas_result_t     result
);
    import qas_pkg::*;

    localparam int PTR_W = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
    localparam int CNT_W = $clog2(ARG_SLOTS + 1);
    localparam int EXT_W = CNT_W + 8;
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(LINE_MAX - 1);
    localparam logic [CNT_W-1:0] SLOTS_MAX = CNT_W'(ARG_SLOTS);

    typedef enum logic [2:0] {
        M_SPACE,
        M_ARG,
        M_SLASH,
        M_SQ,
        M_SQ_SLASH,
        M_DQ,
        M_DQ_SLASH
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              is_ws;
    logic              room;
    logic              wen;
    logic [7:0]        wbyte;
    logic              men;
    logic [1:0]        st;
    logic [PTR_W+7:0]  pos_ext;
    logic [EXT_W-1:0]  cnt_ext;
    logic [EXT_W-1:0]  total_ext;

    assign is_ws = (char_byte == CHAR_SPACE) ||
                   ((char_byte >= CHAR_TAB) && (char_byte <= CHAR_CR));
    assign cnt_ext = {8'd0, cnt_reg};
    assign room = (cnt_reg < SLOTS_MAX) && (cnt_ext < EXT_W'(argument_limit));

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        wen       = 1'b0;
        wbyte     = CHAR_NUL;
        men       = 1'b0;
        st        = STATUS_OK;
        if (end_of_text) begin
            case (mode_reg)
                M_ARG:                          wen = 1'b1;
                M_SLASH, M_SQ_SLASH, M_DQ_SLASH: st = STATUS_OPEN_ESCAPE;
                M_SQ:                           st = STATUS_OPEN_SINGLE;
                M_DQ:                           st = STATUS_OPEN_DOUBLE;
                default:                        st = STATUS_OK;
            endcase
        end else begin
            case (mode_reg)
                M_SPACE: begin
                    if (!is_ws) begin
                        if (room) begin
                            men      = 1'b1;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        if (char_byte == CHAR_BACKSLASH) begin
                            mode_next = M_SLASH;
                        end else if (char_byte == CHAR_SINGLE_QUOTE) begin
                            mode_next = M_SQ;
                        end else if (char_byte == CHAR_DOUBLE_QUOTE) begin
                            mode_next = M_DQ;
                        end else begin
                            wen       = 1'b1;
                            wbyte     = char_byte;
                            mode_next = M_ARG;
                        end
                    end
                end
                M_ARG: begin
                    if (is_ws) begin
                        wen       = 1'b1;
                        mode_next = M_SPACE;
                    end else if (char_byte == CHAR_SINGLE_QUOTE) begin
                        mode_next = M_SQ;
                    end else if (char_byte == CHAR_DOUBLE_QUOTE) begin
                        mode_next = M_DQ;
                    end else if (char_byte == CHAR_BACKSLASH) begin
                        mode_next = M_SLASH;
                    end else begin
                        wen   = 1'b1;
                        wbyte = char_byte;
                    end
                end
                M_SLASH: begin
                    wen       = 1'b1;
                    wbyte     = char_byte;
                    mode_next = M_ARG;
                end
                M_SQ: begin
                    if (char_byte == CHAR_SINGLE_QUOTE) begin
                        mode_next = M_ARG;
                    end else if (char_byte == CHAR_BACKSLASH) begin
                        mode_next = M_SQ_SLASH;
                    end else begin
                        wen   = 1'b1;
                        wbyte = char_byte;
                    end
                end
                M_SQ_SLASH: begin
                    wen       = 1'b1;
                    wbyte     = char_byte;
                    mode_next = M_SQ;
                end
                M_DQ: begin
                    if (char_byte == CHAR_DOUBLE_QUOTE) begin
                        mode_next = M_ARG;
                    end else if (char_byte == CHAR_BACKSLASH) begin
                        mode_next = M_DQ_SLASH;
                    end else begin
                        wen   = 1'b1;
                        wbyte = char_byte;
                    end
                end
                M_DQ_SLASH: begin
                    wen       = 1'b1;
                    wbyte     = char_byte;
                    mode_next = M_DQ;
                end
                default: begin
                    mode_next = M_SPACE;
                end
            endcase
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        if (wen && (ptr_reg < PTR_LAST)) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    assign pos_ext   = {8'd0, ptr_reg};
    assign total_ext = {8'd0, cnt_next};

    always_comb begin
        result.write_enable   = wen;
        result.write_byte     = wbyte;
        result.write_position = pos_ext[7:0];
        result.mark_enable    = men;
        result.mark_slot      = men ? cnt_ext[3:0] : 4'd0;
        result.done_res       = end_of_text;
        result.status         = st;
        result.argument_total = total_ext[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_SPACE;
            ptr_reg  <= '0;
            cnt_reg  <= '0;
        end else if (load) begin
            if (end_of_text) begin
                mode_reg <= M_SPACE;
                ptr_reg  <= '0;
                cnt_reg  <= '0;
            end else begin
                mode_reg <= mode_next;
                ptr_reg  <= ptr_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/quoted_argument_splitter_unit.sv]
// ============================================================================
// quoted_argument_splitter_unit
// Splits a command line into shell-style arguments in place, one byte per
// request, with backslash escapes and single and double quotes.
// ============================================================================
// The block takes one request per clock cycle, back to back, unless the
// receiver holds m_ready low, and returns one result per request through
// the input register and then the result register. The rate is set by the
// single mode, pointer and count update that each byte needs. An end-of-text
// request reports the status and argument count and returns the splitter to
// its initial state; the argument limit register keeps its value.
`default_nettype none

module quoted_argument_splitter_unit #(
    parameter int LINE_MAX  = 256,
    parameter int ARG_SLOTS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_wen,
    input  wire logic [4:0] cfg_wdata,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_byte,
    input  wire logic       s_end_of_text,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_write_enable,
    output logic [7:0]      m_write_byte,
    output logic [7:0]      m_write_position,
    output logic            m_mark_enable,
    output logic [3:0]      m_mark_slot,
    output logic            m_done_res,
    output logic [1:0]      m_status,
    output logic [4:0]      m_argument_total
);
    import qas_pkg::*;

    logic [4:0]  argument_limit_reg;
    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        end_reg;
    logic        out_valid_reg;
    qas_result_t result_reg;
    qas_result_t core_res;
    logic        out_advance;
    logic        core_load;

    assign out_advance = !out_valid_reg || m_ready;
    assign core_load   = in_valid_reg && out_advance;
    assign s_ready     = !in_valid_reg || out_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            argument_limit_reg <= LIMIT_RESET;
        end else if (cfg_wen) begin
            argument_limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_byte;
            end_reg  <= s_end_of_text;
        end
    end

    qas_core #(
        .LINE_MAX  (LINE_MAX),
        .ARG_SLOTS (ARG_SLOTS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (core_load),
        .char_byte      (char_reg),
        .end_of_text    (end_reg),
        .argument_limit (argument_limit_reg),
        .result         (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_load) begin
            result_reg <= core_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_write_enable   = result_reg.write_enable;
    assign m_write_byte     = result_reg.write_byte;
    assign m_write_position = result_reg.write_position;
    assign m_mark_enable    = result_reg.mark_enable;
    assign m_mark_slot      = result_reg.mark_slot;
    assign m_done_res       = result_reg.done_res;
    assign m_status         = result_reg.status;
    assign m_argument_total = result_reg.argument_total;

    // After an end-of-text request the pointer and count start again from zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (core_load && core_res.done_res) |=>
            (core_res.write_position == 8'd0 && core_res.mark_slot == 4'd0))
        else $error("splitter state not cleared after end of text");

    // A start mark never comes with the end-of-text result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> !m_mark_enable)
        else $error("argument start marked on end of text");

    // Status is only reported on the end-of-text result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_done_res) |-> (m_status == STATUS_OK))
        else $error("status reported before end of text");

    // A result is taken from the input register exactly when the core advances.
    assert property (@(posedge aclk) disable iff (!aresetn)
        core_load |=> out_valid_reg)
        else $error("loaded result lost");

endmodule

`default_nettype wire

[test/quoted_argument_splitter_unit_tb.sv]
// ============================================================================
// quoted_argument_splitter_unit_tb
// Sends command-line bytes and end-of-text requests through the splitter,
// predicts every write, argument mark and final status from its own copy of
// the tokenizer state, and compares each result field by field. The argument
// limit is stepped through several values between lines, and both channels
// idle at random, including one long receiver hold that backs up the input.
// ============================================================================
`default_nettype none

module quoted_argument_splitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qas_pkg::*;

    localparam int LINE_MAX       = 256;
    localparam int ARG_SLOTS      = 16;
    localparam int LATENCY        = 2;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 65;
    localparam int LONG_LINE      = 320;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;
    localparam logic [8:0] END_MARK = 9'h100;

    typedef enum logic [2:0] {
        BETWEEN_ARGS,
        IN_ARG,
        ESCAPE,
        IN_SINGLE,
        SINGLE_ESCAPE,
        IN_DOUBLE,
        DOUBLE_ESCAPE
    } split_mode_t;

    class split_scoreboard;
        split_mode_t mode;
        int          write_ptr;
        int          arg_count;
        int          arg_limit;
        int          errors;
        qas_result_t predicted_steps[$];

        function new();
            mode      = BETWEEN_ARGS;
            write_ptr = 0;
            arg_count = 0;
            arg_limit = LIMIT_RESET;
            errors    = 0;
        endfunction

        function bit is_blank(logic [7:0] ch);
            return ch == CHAR_SPACE || (ch >= CHAR_TAB && ch <= CHAR_CR);
        endfunction

        function int pending();
            return predicted_steps.size();
        endfunction

        function void take_byte(logic [7:0] ch, logic eot);
            qas_result_t r;
            int          slots;
            r = '0;
            r.write_position = write_ptr[7:0];
            slots = (arg_limit < ARG_SLOTS) ? arg_limit : ARG_SLOTS;
            if (eot) begin
                r.done_res = 1'b1;
                case (mode)
                    IN_ARG: r.write_enable = 1'b1;
                    ESCAPE, SINGLE_ESCAPE, DOUBLE_ESCAPE: r.status = STATUS_OPEN_ESCAPE;
                    IN_SINGLE: r.status = STATUS_OPEN_SINGLE;
                    IN_DOUBLE: r.status = STATUS_OPEN_DOUBLE;
                    default: ;
                endcase
            end else begin
                case (mode)
                    BETWEEN_ARGS: begin
                        if (!is_blank(ch)) begin
                            if (arg_count < slots) begin
                                r.mark_enable = 1'b1;
                                r.mark_slot   = 4'(arg_count);
                                arg_count++;
                            end
                            if (ch == CHAR_BACKSLASH) mode = ESCAPE;
                            else if (ch == CHAR_SINGLE_QUOTE) mode = IN_SINGLE;
                            else if (ch == CHAR_DOUBLE_QUOTE) mode = IN_DOUBLE;
                            else begin
                                r.write_enable = 1'b1;
                                r.write_byte   = ch;
                                mode           = IN_ARG;
                            end
                        end
                    end
                    IN_ARG: begin
                        if (is_blank(ch)) begin
                            r.write_enable = 1'b1;
                            mode           = BETWEEN_ARGS;
                        end else if (ch == CHAR_SINGLE_QUOTE) mode = IN_SINGLE;
                        else if (ch == CHAR_DOUBLE_QUOTE) mode = IN_DOUBLE;
                        else if (ch == CHAR_BACKSLASH) mode = ESCAPE;
                        else begin
                            r.write_enable = 1'b1;
                            r.write_byte   = ch;
                        end
                    end
                    ESCAPE: begin
                        r.write_enable = 1'b1;
                        r.write_byte   = ch;
                        mode           = IN_ARG;
                    end
                    IN_SINGLE: begin
                        if (ch == CHAR_SINGLE_QUOTE) mode = IN_ARG;
                        else if (ch == CHAR_BACKSLASH) mode = SINGLE_ESCAPE;
                        else begin
                            r.write_enable = 1'b1;
                            r.write_byte   = ch;
                        end
                    end
                    SINGLE_ESCAPE: begin
                        r.write_enable = 1'b1;
                        r.write_byte   = ch;
                        mode           = IN_SINGLE;
                    end
                    IN_DOUBLE: begin
                        if (ch == CHAR_DOUBLE_QUOTE) mode = IN_ARG;
                        else if (ch == CHAR_BACKSLASH) mode = DOUBLE_ESCAPE;
                        else begin
                            r.write_enable = 1'b1;
                            r.write_byte   = ch;
                        end
                    end
                    DOUBLE_ESCAPE: begin
                        r.write_enable = 1'b1;
                        r.write_byte   = ch;
                        mode           = IN_DOUBLE;
                    end
                    default: mode = BETWEEN_ARGS;
                endcase
            end
            if (r.write_enable && write_ptr < LINE_MAX - 1) write_ptr++;
            r.argument_total = 5'(arg_count);
            if (eot) begin
                mode      = BETWEEN_ARGS;
                write_ptr = 0;
                arg_count = 0;
            end
            predicted_steps.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void compare_step(qas_result_t got);
            qas_result_t want;
            if (predicted_steps.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            want = predicted_steps.pop_front();
            compare_field("write_enable", want.write_enable, got.write_enable);
            compare_field("write_byte", want.write_byte, got.write_byte);
            compare_field("write_position", want.write_position, got.write_position);
            compare_field("mark_enable", want.mark_enable, got.mark_enable);
            compare_field("mark_slot", want.mark_slot, got.mark_slot);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("status", want.status, got.status);
            compare_field("argument_total", want.argument_total, got.argument_total);
        endfunction
    endclass

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wen       = 1'b0;
    logic [4:0] cfg_wdata     = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte   = '0;
    logic       s_end_of_text = 1'b0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_write_enable;
    logic [7:0] m_write_byte;
    logic [7:0] m_write_position;
    logic       m_mark_enable;
    logic [3:0] m_mark_slot;
    logic       m_done_res;
    logic [1:0] m_status;
    logic [4:0] m_argument_total;

    bit             steady_flow  = 1'b0;
    bit             hold_request = 1'b0;
    int             idle_cycles  = 0;
    int             phase_requests;
    split_scoreboard scoreboard = new();

    quoted_argument_splitter_unit #(
        .LINE_MAX (LINE_MAX),
        .ARG_SLOTS(ARG_SLOTS)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wen         (cfg_wen),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_byte     (s_char_byte),
        .s_end_of_text   (s_end_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_write_byte    (m_write_byte),
        .m_write_position(m_write_position),
        .m_mark_enable   (m_mark_enable),
        .m_mark_slot     (m_mark_slot),
        .m_done_res      (m_done_res),
        .m_status        (m_status),
        .m_argument_total(m_argument_total)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] line_byte();
        int roll;
        int pick;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 8'($urandom_range(8'h61, 8'h7A));
        if (roll < 60) begin
            pick = $urandom_range(0, 5);
            return (pick == 0) ? CHAR_SPACE : 8'(CHAR_TAB + pick - 1);
        end
        if (roll < 70) return CHAR_BACKSLASH;
        if (roll < 78) return CHAR_SINGLE_QUOTE;
        if (roll < 86) return CHAR_DOUBLE_QUOTE;
        return 8'($urandom);
    endfunction

    function automatic int line_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 20);
        if (roll < 97) return $urandom_range(21, 70);
        return 0;
    endfunction

    task automatic send_request(input logic [7:0] ch, input logic eot);
        int gap;
        gap = steady_flow ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_byte   <= ch;
        s_end_of_text <= eot;
        do @(posedge aclk); while (!s_ready);
        scoreboard.take_byte(ch, eot);
        phase_requests++;
    endtask

    task automatic send_line(input int len, input bit terminate);
        for (int i = 0; i < len; i++) send_request(line_byte(), 1'b0);
        if (terminate) send_request(8'($urandom), 1'b1);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (scoreboard.pending() > 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [4:0] value);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        scoreboard.arg_limit = value;
        @(posedge aclk);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady_flow) begin
                stall_left = idle_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            scoreboard.compare_step('{m_write_enable, m_write_byte, m_write_position,
                                      m_mark_enable, m_mark_slot, m_done_res, m_status,
                                      m_argument_total});
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [8:0] directed[$];
        logic [4:0] limits[$];
        directed = '{
            END_MARK,
            {1'b0, CHAR_SPACE}, {1'b0, CHAR_TAB}, 9'h000, 9'h0FF, {1'b0, CHAR_LF},
            {1'b0, CHAR_VT}, {1'b0, CHAR_FF}, {1'b0, CHAR_CR},
            {1'b0, CHAR_SINGLE_QUOTE}, {1'b0, CHAR_BACKSLASH}, 9'h078,
            {1'b0, CHAR_SINGLE_QUOTE}, {1'b0, CHAR_DOUBLE_QUOTE}, {1'b0, CHAR_BACKSLASH},
            {1'b0, CHAR_DOUBLE_QUOTE}, {1'b0, CHAR_DOUBLE_QUOTE}, {1'b0, CHAR_BACKSLASH},
            9'h071, END_MARK,
            {1'b0, CHAR_BACKSLASH}, END_MARK,
            {1'b0, CHAR_SINGLE_QUOTE}, END_MARK,
            {1'b0, CHAR_DOUBLE_QUOTE}, END_MARK
        };
        limits = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd16, 5'd15, 5'($urandom_range(3, 14))};
        phase_requests = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i][8]) send_request(8'($urandom), 1'b1);
            else send_request(directed[i][7:0], 1'b0);
        end

        foreach (limits[p]) begin
            write_limit(limits[p]);
            steady_flow    = (p % 2 == 1);
            phase_requests = 0;
            if (p == 1) send_line(LONG_LINE, 1'b1);
            if (p == 3) hold_request = 1'b1;
            while (phase_requests < PHASE_ITEMS)
                send_line(line_length(), $urandom_range(0, 9) != 0);
            send_request(8'($urandom), 1'b1);
        end

        steady_flow = 1'b0;
        wait_drained();
        if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
design/qas_pkg.sv
design/qas_core.sv
design/quoted_argument_splitter_unit.sv
test/quoted_argument_splitter_unit_tb.sv
